### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the packet framer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while reset is released.
`define SIPF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising edge of clk, reset included.
`define SIPF_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/sipf_pkg.sv
// ----------------------------------------------------------------------------
// sipf_pkg
// Types, constants and the CRC-16 byte step shared by the packet framer.
// ----------------------------------------------------------------------------
package sipf_pkg;

	localparam int unsigned MAX_PARAMS = 1024;
	localparam int unsigned COUNT_W    = 11;

	localparam logic [COUNT_W-1:0] COUNT_SAT     = '1;
	localparam logic [COUNT_W-1:0] MAX_COUNT     = COUNT_W'(MAX_PARAMS);
	localparam logic [15:0]        CRC_POLY      = 16'h8005;
	localparam logic [7:0]         HDR_FF        = 8'hFF;
	localparam logic [7:0]         HDR_FD        = 8'hFD;
	localparam logic [7:0]         HDR_RSV       = 8'h00;
	localparam logic [7:0]         DEVICE_ID_RST = 8'hFE;
	localparam logic [3:0]         PARAM_OFFSET  = 4'd8;

	// Byte position inside the frame
	typedef enum logic [3:0] {
		POS_HDR0   = 4'd0,
		POS_HDR1   = 4'd1,
		POS_HDR2   = 4'd2,
		POS_RSV    = 4'd3,
		POS_ID     = 4'd4,
		POS_LEN_LO = 4'd5,
		POS_LEN_HI = 4'd6,
		POS_INSTR  = 4'd7,
		POS_PARAM  = 4'd8,
		POS_CRC_LO = 4'd9,
		POS_CRC_HI = 4'd10
	} pos_t;

	typedef struct packed {
		logic [7:0]         param_byte;
		logic               first_param;
		logic               last_param;
		logic [7:0]         instruction_code;
		logic [COUNT_W-1:0] param_count;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
		logic       count_mismatch;
	} beat_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### hw/rtl/sipf_in_reg.sv
// ----------------------------------------------------------------------------
// sipf_in_reg
// Input item register; holds one item until the emitter retires it.
// ----------------------------------------------------------------------------
module sipf_in_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  sipf_pkg::item_t             in_item,
	input  logic                        done,
	output logic                        item_valid,
	output sipf_pkg::item_t             item
);
	import sipf_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  load;

	assign in_stall   = valid_s1 && !done;
	assign load       = in_valid && !in_stall;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

### hw/rtl/sipf_emitter.sv
// ----------------------------------------------------------------------------
// sipf_emitter
// Walks the held item through its frame bytes, one beat per cycle while the
// output register is ready, and keeps the CRC, byte count and packet state.
// ----------------------------------------------------------------------------
module sipf_emitter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [7:0]        cfg_data,
	input  logic              item_valid,
	input  sipf_pkg::item_t   item,
	input  logic              out_ready,
	output logic              beat_valid,
	output sipf_pkg::beat_t   beat,
	output logic              done
);
	import sipf_pkg::*;

	`include "assert_macros.svh"

	logic [7:0]         device_id_q;
	logic [15:0]        crc_q;
	logic [COUNT_W-1:0] seen_q;
	logic [COUNT_W-1:0] declared_q;
	logic               in_packet_q;
	logic [3:0]         idx_q;

	pos_t               pos;
	logic               skip;
	logic               emit;
	logic               is_final;
	logic [11:0]        len;
	logic [7:0]         data;
	logic [15:0]        crc_base;
	logic [COUNT_W-1:0] seen_base;
	logic               mismatch;

	assign pos       = pos_t'(item.first_param ? idx_q : idx_q + PARAM_OFFSET);
	assign skip      = item_valid && !item.first_param && !in_packet_q;
	assign emit      = item_valid && !skip && out_ready;
	assign is_final  = item.last_param ? (pos == POS_CRC_HI) : (pos == POS_PARAM);
	assign done      = skip || (emit && is_final);
	assign len       = {1'b0, item.param_count} + 12'd3;
	assign crc_base  = (pos == POS_HDR0) ? 16'h0000 : crc_q;
	assign seen_base = (seen_q == COUNT_SAT) ? seen_q : seen_q + 1'b1;
	assign mismatch  = (seen_q != declared_q) || (declared_q == '0) ||
		(declared_q > MAX_COUNT) || (seen_q == COUNT_SAT);

	always_comb begin
		unique case (pos)
			POS_HDR0, POS_HDR1: data = HDR_FF;
			POS_HDR2:           data = HDR_FD;
			POS_RSV:            data = HDR_RSV;
			POS_ID:             data = device_id_q;
			POS_LEN_LO:         data = len[7:0];
			POS_LEN_HI:         data = {4'h0, len[11:8]};
			POS_INSTR:          data = item.instruction_code;
			POS_PARAM:          data = item.param_byte;
			POS_CRC_LO:         data = crc_q[7:0];
			POS_CRC_HI:         data = crc_q[15:8];
			default:            data = 8'h00;
		endcase
	end

	assign beat_valid          = emit;
	assign beat.out_byte       = data;
	assign beat.packet_end     = (pos == POS_CRC_HI);
	assign beat.count_mismatch = (pos == POS_CRC_HI) && mismatch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= DEVICE_ID_RST;
		end else if (cfg_valid) begin
			device_id_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			seen_q      <= '0;
			declared_q  <= '0;
			in_packet_q <= 1'b0;
			idx_q       <= '0;
		end else if (emit) begin
			idx_q <= is_final ? 4'd0 : idx_q + 4'd1;
			if (pos <= POS_PARAM) begin
				crc_q <= crc16_byte(crc_base, data);
			end
			if (pos == POS_HDR0) begin
				declared_q  <= item.param_count;
				seen_q      <= '0;
				in_packet_q <= 1'b1;
			end
			if (pos == POS_PARAM) begin
				seen_q <= seen_base;
			end
			if (pos == POS_CRC_HI) begin
				in_packet_q <= 1'b0;
			end
		end
	end

	`SIPF_ASSERT(a_pos_range, clk, arst_n, item_valid |-> (pos <= POS_CRC_HI), "frame position out of range")
	`SIPF_ASSERT(a_open_after_hdr, clk, arst_n, (emit && pos == POS_HDR0) |=> in_packet_q, "packet not opened after header")
	`SIPF_ASSERT(a_close_after_crc, clk, arst_n, (emit && pos == POS_CRC_HI) |=> (!in_packet_q && idx_q == 4'd0), "packet not closed after CRC")

endmodule

### hw/rtl/sipf_out_reg.sv
// ----------------------------------------------------------------------------
// sipf_out_reg
// Result register on the output channel; frees itself on a taken beat.
// ----------------------------------------------------------------------------
module sipf_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            beat_valid,
	input  sipf_pkg::beat_t beat,
	output logic            out_ready,
	output logic            out_valid,
	input  logic            out_stall,
	output sipf_pkg::beat_t out_beat
);
	import sipf_pkg::*;

	logic  valid_q;
	beat_t beat_q;

	assign out_ready = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_beat  = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && beat_valid) begin
			beat_q <= beat;
		end
	end

endmodule

### hw/rtl/servo_instruction_packet_framer_core.sv
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer_core
// The held item is registered in the input register, each beat in the output register.
// Throughput: one output beat per cycle while out_stall is low; an item holds the
// input until its last beat is emitted, with 1 beat for pass-through, 3 for last,
// 9 for first and 11 for first+last. Items outside a packet are dropped without a beat.
// Reset clears packet state and loads device id 254; no clearing pass.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [7:0]                          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          param_byte,
	input  logic                                first_param,
	input  logic                                last_param,
	input  logic [7:0]                          instruction_code,
	input  logic [sipf_pkg::COUNT_W-1:0]        param_count,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          out_byte,
	output logic                                packet_end,
	output logic                                count_mismatch
);
	import sipf_pkg::*;

	item_t in_item;
	item_t item;
	logic  item_valid;
	logic  done;
	logic  out_ready;
	logic  beat_valid;
	beat_t beat;
	beat_t out_beat;

	assign cfg_ready = 1'b1;

	assign in_item.param_byte       = param_byte;
	assign in_item.first_param      = first_param;
	assign in_item.last_param       = last_param;
	assign in_item.instruction_code = instruction_code;
	assign in_item.param_count      = param_count;

	sipf_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.done       (done),
		.item_valid (item_valid),
		.item       (item)
	);

	sipf_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.out_ready  (out_ready),
		.beat_valid (beat_valid),
		.beat       (beat),
		.done       (done)
	);

	sipf_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (beat_valid),
		.beat       (beat),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat)
	);

	assign out_byte       = out_beat.out_byte;
	assign packet_end     = out_beat.packet_end;
	assign count_mismatch = out_beat.count_mismatch;

endmodule

### dv/servo_instruction_packet_framer_core_tb.sv
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer_core_tb
// Drives parameter bytes into the framer and checks every framed output beat
// (header, id, length, instruction, body, CRC-16 and the end/mismatch flags)
// against an in-bench model of the framing and CRC. A short table of directed
// bytes comes first. Random packets follow, some of them broken or abandoned,
// with stray bytes mixed in. The device id is rewritten between phases.
// Both sides pause at random outside the last phase, and the output side holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sipf_pkg::*;

	localparam int unsigned CYCLE_LIMIT      = 2_000_000;
	localparam logic [7:0]  INSTR_SYNC_WRITE = 8'h83;
	localparam logic [7:0]  INSTR_SYNC_READ  = 8'h82;
	localparam int          NO_CHECK         = -1;
	localparam int          N_DIRECTED       = 16;

	typedef struct packed {
		logic [7:0]         pb;
		logic               first;
		logic               last;
		logic [7:0]         instr;
		logic [COUNT_W-1:0] cnt;
		int                 exp_id;
		int                 exp_mis;
	} vec_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [7:0]         cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         param_byte;
	logic               first_param;
	logic               last_param;
	logic [7:0]         instruction_code;
	logic [COUNT_W-1:0] param_count;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         out_byte;
	logic               packet_end;
	logic               count_mismatch;

	// framing model state
	logic [7:0]         dev_id;
	logic [15:0]        crc_acc;
	logic [COUNT_W-1:0] seen_cnt;
	logic [COUNT_W-1:0] decl_cnt;
	logic               open_pkt;

	beat_t       frame_out[$];
	beat_t       tx_expect_q[$];
	int unsigned cycle_cnt;
	int unsigned mismatch_cnt;
	bit          calm;
	bit          hold_req;
	bit          hold_done;

	vec_row_t dir_vec [N_DIRECTED];

	servo_instruction_packet_framer_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.param_byte       (param_byte),
		.first_param      (first_param),
		.last_param       (last_param),
		.instruction_code (instruction_code),
		.param_count      (param_count),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_byte         (out_byte),
		.packet_end       (packet_end),
		.count_mismatch   (count_mismatch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return crc;
	endfunction

	function automatic void put_data(input logic [7:0] b);
		crc_acc = crc_step(crc_acc, b);
		frame_out.push_back('{out_byte: b, packet_end: 1'b0, count_mismatch: 1'b0});
	endfunction

	function automatic void frame_param(input item_t it);
		logic [15:0] len;
		logic        mis;
		frame_out.delete();
		if (it.first_param) begin
			len      = 16'(it.param_count) + 16'd3;
			crc_acc  = '0;
			decl_cnt = it.param_count;
			seen_cnt = '0;
			open_pkt = 1'b1;
			put_data(HDR_FF);
			put_data(HDR_FF);
			put_data(HDR_FD);
			put_data(HDR_RSV);
			put_data(dev_id);
			put_data(len[7:0]);
			put_data(len[15:8]);
			put_data(it.instruction_code);
		end
		if (open_pkt) begin
			put_data(it.param_byte);
			if (seen_cnt != COUNT_SAT) begin
				seen_cnt++;
			end
			if (it.last_param) begin
				mis = (seen_cnt != decl_cnt) || (decl_cnt == '0) ||
				      (decl_cnt > MAX_COUNT) || (seen_cnt == COUNT_SAT);
				frame_out.push_back('{out_byte: crc_acc[7:0], packet_end: 1'b0,
				                      count_mismatch: 1'b0});
				frame_out.push_back('{out_byte: crc_acc[15:8], packet_end: 1'b1,
				                      count_mismatch: mis});
				open_pkt = 1'b0;
			end
		end
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.param_byte       = 8'($urandom);
		it.first_param      = 1'($urandom);
		it.last_param       = 1'($urandom);
		it.instruction_code = 8'($urandom);
		it.param_count      = COUNT_W'($urandom);
		return it;
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return COUNT_W'($urandom_range(1, 6));
		end else if (r < 85) begin
			return COUNT_W'($urandom_range(7, 16));
		end
		return COUNT_W'($urandom_range(0, 2047));
	endfunction

	function automatic logic [7:0] pick_instr();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0) begin
			return INSTR_SYNC_WRITE;
		end else if (r == 1) begin
			return INSTR_SYNC_READ;
		end
		return 8'($urandom);
	endfunction

	task automatic send_param(input item_t it, input int exp_id, input int exp_mis);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid         <= 1'b1;
		param_byte       <= it.param_byte;
		first_param      <= it.first_param;
		last_param       <= it.last_param;
		instruction_code <= it.instruction_code;
		param_count      <= it.param_count;
		do @(posedge clk); while (in_stall);
		frame_param(it);
		if (exp_id != NO_CHECK && it.first_param) begin
			frame_out[4].out_byte = exp_id[7:0];
		end
		if (exp_mis != NO_CHECK && it.last_param && frame_out.size() > 0) begin
			frame_out[$].count_mismatch = exp_mis[0];
		end
		foreach (frame_out[k]) begin
			tx_expect_q.push_back(frame_out[k]);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tx_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_device_id(input logic [7:0] id);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= id;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dev_id = id;
	endtask

	task automatic send_random_traffic(input int n_items);
		int          sent;
		int          kind;
		int          len;
		int          n_send;
		logic [COUNT_W-1:0] cnt;
		logic [7:0]  instr;
		item_t       it;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				it             = rand_item();
				it.first_param = 1'b0;
				send_param(it, NO_CHECK, NO_CHECK);
				sent++;
			end else begin
				cnt   = pick_count();
				instr = pick_instr();
				if ($urandom_range(0, 9) < 8 && cnt != '0 && cnt <= 16) begin
					len = int'(cnt);
				end else begin
					len = $urandom_range(1, 8);
				end
				// drop the tail of some packets so the next start abandons them
				n_send = (kind < 18) ? $urandom_range(1, len) : len;
				for (int k = 0; k < n_send; k++) begin
					it             = rand_item();
					it.first_param = (k == 0);
					it.last_param  = (k == len - 1) && (n_send == len);
					if (k == 0) begin
						it.instruction_code = instr;
						it.param_count      = cnt;
					end
					send_param(it, NO_CHECK, NO_CHECK);
					sent++;
				end
			end
		end
	endtask

	initial begin : rx_pace
		int n;
		out_stall = 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				n = 400;
			end else begin
				n = idle_len();
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		beat_t want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else if (arst_n && out_valid && !out_stall) begin
			if (tx_expect_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got byte %h end %b mis %b",
				         $time, out_byte, packet_end, count_mismatch);
				mismatch_cnt++;
			end else begin
				want = tx_expect_q.pop_front();
				if (out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %h, got %h",
					         $time, want.out_byte, out_byte);
					mismatch_cnt++;
				end
				if (packet_end !== want.packet_end) begin
					$display("%0t: packet_end expected %b, got %b",
					         $time, want.packet_end, packet_end);
					mismatch_cnt++;
				end
				if (count_mismatch !== want.count_mismatch) begin
					$display("%0t: count_mismatch expected %b, got %b",
					         $time, want.count_mismatch, count_mismatch);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin : stimulus
		item_t it;
		cycle_cnt        = 0;
		mismatch_cnt     = 0;
		calm             = 1'b0;
		hold_req         = 1'b0;
		hold_done        = 1'b0;
		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		cfg_data         = '0;
		in_valid         = 1'b0;
		param_byte       = '0;
		first_param      = 1'b0;
		last_param       = 1'b0;
		instruction_code = '0;
		param_count      = '0;
		dev_id           = DEVICE_ID_RST;
		crc_acc          = '0;
		seen_cnt         = '0;
		decl_cnt         = '0;
		open_pkt         = 1'b0;

		dir_vec = '{
			'{8'h00, 1'b1, 1'b1, INSTR_SYNC_WRITE, 11'd1,    254,      0},
			'{8'hFF, 1'b0, 1'b1, 8'hFF,            11'h7FF,  NO_CHECK, NO_CHECK},
			'{8'hFF, 1'b1, 1'b0, INSTR_SYNC_READ,  11'd2,    254,      NO_CHECK},
			'{8'h00, 1'b0, 1'b1, 8'h00,            11'd0,    NO_CHECK, 0},
			'{8'hFF, 1'b1, 1'b1, 8'hFF,            11'd0,    NO_CHECK, 1},
			'{8'h00, 1'b1, 1'b1, 8'h00,            11'h7FF,  NO_CHECK, 1},
			'{8'hA5, 1'b1, 1'b0, 8'h01,            11'd3,    NO_CHECK, NO_CHECK},
			'{8'h5A, 1'b0, 1'b0, 8'h02,            11'd5,    NO_CHECK, NO_CHECK},
			'{8'h3C, 1'b1, 1'b1, 8'h03,            11'd1,    NO_CHECK, 0},
			'{8'h81, 1'b1, 1'b0, 8'h04,            11'd3,    NO_CHECK, NO_CHECK},
			'{8'h7E, 1'b0, 1'b1, 8'h05,            11'd0,    NO_CHECK, 1},
			'{8'h10, 1'b1, 1'b0, 8'h06,            11'd1,    NO_CHECK, NO_CHECK},
			'{8'h20, 1'b0, 1'b0, 8'h07,            11'd0,    NO_CHECK, NO_CHECK},
			'{8'h30, 1'b0, 1'b1, 8'h08,            11'd0,    NO_CHECK, 1},
			'{8'h12, 1'b0, 1'b0, 8'h55,            11'd9,    NO_CHECK, NO_CHECK},
			'{8'h80, 1'b1, 1'b1, 8'h00,            11'd1024, NO_CHECK, 1}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_vec[r]) begin
			it.param_byte       = dir_vec[r].pb;
			it.first_param      = dir_vec[r].first;
			it.last_param       = dir_vec[r].last;
			it.instruction_code = dir_vec[r].instr;
			it.param_count      = dir_vec[r].cnt;
			send_param(it, dir_vec[r].exp_id, dir_vec[r].exp_mis);
		end

		write_device_id(8'h00);
		send_random_traffic(64);

		write_device_id(8'hFF);
		hold_req = 1'b1;
		send_random_traffic(64);

		write_device_id(8'($urandom));
		calm = 1'b1;
		send_random_traffic(64);
		calm = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sipf_pkg.sv
hw/rtl/sipf_in_reg.sv
hw/rtl/sipf_emitter.sv
hw/rtl/sipf_out_reg.sv
hw/rtl/servo_instruction_packet_framer_core.sv
dv/servo_instruction_packet_framer_core_tb.sv
